FILE: src/digit_gene_formula_evaluator_macros.svh
// Assertion helpers shared by the evaluator. Both expect clk and rst_n in scope.
`ifndef DIGIT_GENE_FORMULA_EVALUATOR_MACROS_SVH
`define DIGIT_GENE_FORMULA_EVALUATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define DGFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define DGFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dgfe_pkg.sv
`default_nettype none

package dgfe_pkg;

  // Field and datapath widths.
  localparam int X_W        = 32;
  localparam int GENE_W     = 44;
  localparam int LEN_W      = 5;
  localparam int DIGIT_W    = 4;
  localparam int MAG_W      = 8;
  localparam int PK_W       = 40;
  localparam int SQ_W       = 33;
  localparam int SQ_FULL_W  = 64;
  localparam int Q_W        = 41;
  localparam int RES_W      = 42;

  // Pipeline shape: abs, multiply, five remainder stages, output.
  localparam int NUM_STAGES = 8;
  localparam int REM_STAGES = 5;
  localparam int REM_BITS   = PK_W / REM_STAGES;

  // Gene rules.
  localparam int REQUIRED_DIGITS = 11;
  localparam int MAX_GENE_DIGITS = 16;

  // Saturation limits at the width of the final sum.
  localparam logic signed [RES_W-1:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [RES_W-1:0] SAT_LO = -42'sd2147483648;

  typedef enum logic [1:0] {
    OP_LINEAR    = 2'd0,
    OP_INVERSE   = 2'd1,
    OP_REMAINDER = 2'd2,
    OP_QUADRATIC = 2'd3
  } op_t;

  typedef enum logic {
    REG_GENE_DIGITS = 1'b0,
    REG_GENE_LENGTH = 1'b1
  } reg_idx_t;

  // Decoded view of the gene registers.
  typedef struct packed {
    op_t              op;
    logic             k_neg;
    logic [MAG_W-1:0] k_mag;
    logic             b_neg;
    logic [MAG_W-1:0] b_mag;
    logic [MAG_W-1:0] divisor;
    logic             short_gene;
  } gene_t;

  // Payload after the multiply stage.
  typedef struct packed {
    logic [PK_W-1:0] pk;
    logic            pneg;
    logic            big;
    logic [SQ_W-1:0] sq;
  } prod_t;

  // Payload through the remainder stages.
  typedef struct packed {
    logic [PK_W-1:0]  pk;
    logic             pneg;
    logic             big;
    logic [Q_W-1:0]   q;
    logic [MAG_W-1:0] rem;
  } rem_t;

  // Tens digit times ten plus units digit; raw nibbles up to 15 give at most 165.
  function automatic logic [MAG_W-1:0] term_mag(input logic [DIGIT_W-1:0] tens,
                                                input logic [DIGIT_W-1:0] units);
    logic [MAG_W-1:0] t8;
    logic [MAG_W-1:0] u8;
    t8 = MAG_W'(tens);
    u8 = MAG_W'(units);
    return (t8 << 3) + (t8 << 1) + u8;
  endfunction

endpackage

`default_nettype wire

FILE: src/dgfe_if.sv
`default_nettype none

// Input item channel.
interface dgfe_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [dgfe_pkg::X_W-1:0]  x_value;
  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

// Result item channel.
interface dgfe_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dgfe_pkg::X_W-1:0]  y_value;
  logic                             gene_error;
  modport source (output valid, output y_value, output gene_error, input ready);
  modport sink   (input valid, input y_value, input gene_error, output ready);
endinterface

// Configuration write channel.
interface dgfe_cfg_if;
  logic                            valid;
  logic                            ready;
  dgfe_pkg::reg_idx_t              reg_index;
  logic [dgfe_pkg::GENE_W-1:0]     wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: src/digit_gene_formula_evaluator.sv
// Digit-gene formula evaluator.
// Channels: in_ch carries x_value items, out_ch returns y_value and gene_error,
// both valid/ready; an item moves at a clock edge with valid and ready high.
// cfg_ch writes gene_digits (index 0) and gene_length (index 1); it is always
// ready and should only be used while no item is in flight.
// The datapath is an eight-stage pipeline: magnitude, multiply, five stages of
// eight remainder steps each (one per dividend byte), and the output register.
// A result is offered once its item has moved from the magnitude stage through to the
// output register; one item per cycle is sustained while out_ch.ready stays high.
// The multiply stage and the byte-wide remainder steps set the stage depth.
// Each stage holds a valid bit and moves only when the stage after it is empty
// or moving, so a stalled receiver fills the bubbles first and then drops
// in_ch.ready; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline, clears gene_digits and
// sets gene_length to sixteen.
`default_nettype none
`include "digit_gene_formula_evaluator_macros.svh"

module digit_gene_formula_evaluator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dgfe_in_if.sink    in_ch,
  dgfe_out_if.source out_ch,
  dgfe_cfg_if.sink   cfg_ch
);
  import dgfe_pkg::*;

  gene_t                    gene;
  logic [NUM_STAGES-1:0]    v_r, v_nxt;
  logic [NUM_STAGES-1:0]    rdy;

  logic                     xneg_r;
  logic [X_W-1:0]           ax_r, ax_nxt;
  logic [SQ_FULL_W-1:0]     sq_full;
  prod_t                    prod_r, prod_nxt;
  rem_t                     rem_r   [REM_STAGES];
  rem_t                     rem_nxt [REM_STAGES];
  logic signed [X_W-1:0]    y_r, y_nxt;
  logic                     err_r, err_nxt;

  dgfe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .gene   (gene)
  );

  // Stage ready chain: a stage loads when it is empty or its successor loads.
  assign rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
  genvar gs;
  generate
    for (gs = 0; gs < NUM_STAGES - 1; gs++) begin : g_rdy
      assign rdy[gs] = !v_r[gs] || rdy[gs+1];
    end
  endgenerate

  // Valid bits travel with the data.
  assign v_nxt[0] = rdy[0] ? in_ch.valid : v_r[0];
  generate
    for (gs = 1; gs < NUM_STAGES; gs++) begin : g_vld
      assign v_nxt[gs] = rdy[gs] ? v_r[gs-1] : v_r[gs];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = rdy[0];

  // Stage 0: sign and magnitude of x.
  assign ax_nxt = in_ch.x_value[X_W-1] ? (~in_ch.x_value + X_W'(1)) : in_ch.x_value;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xneg_r <= in_ch.x_value[X_W-1];
      ax_r   <= ax_nxt;
    end
  end

  // Stage 1: |k|*|x| and |x|*|x|; the square is flagged when above 2^32.
  assign sq_full = SQ_FULL_W'(ax_r) * SQ_FULL_W'(ax_r);

  always_comb begin
    prod_nxt.pk   = PK_W'(gene.k_mag) * PK_W'(ax_r);
    prod_nxt.pneg = xneg_r ^ gene.k_neg;
    prod_nxt.big  = (sq_full[SQ_FULL_W-1:SQ_W] != '0) ||
                    (sq_full[SQ_W-1] && (sq_full[SQ_W-2:0] != '0));
    prod_nxt.sq   = sq_full[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod_r <= prod_nxt;
    end
  end

  // Stages 2 to 6: remainder of |k*x| by the divisor, one byte per stage.
  // The first of them also forms |k|*x*x.
  generate
    for (gs = 0; gs < REM_STAGES; gs++) begin : g_rem
      logic [MAG_W-1:0] rem_step;
      if (gs == 0) begin : g_first
        dgfe_rem8 u_rem8 (
          .rem_in  ('0),
          .bits    (prod_r.pk[PK_W-1 -: REM_BITS]),
          .divisor (gene.divisor),
          .rem_out (rem_step)
        );
        always_comb begin
          rem_nxt[gs].pk   = prod_r.pk;
          rem_nxt[gs].pneg = prod_r.pneg;
          rem_nxt[gs].big  = prod_r.big;
          rem_nxt[gs].q    = Q_W'(gene.k_mag) * Q_W'(prod_r.sq);
          rem_nxt[gs].rem  = rem_step;
        end
      end else begin : g_next
        dgfe_rem8 u_rem8 (
          .rem_in  (rem_r[gs-1].rem),
          .bits    (rem_r[gs-1].pk[PK_W-1-gs*REM_BITS -: REM_BITS]),
          .divisor (gene.divisor),
          .rem_out (rem_step)
        );
        always_comb begin
          rem_nxt[gs]     = rem_r[gs-1];
          rem_nxt[gs].rem = rem_step;
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[gs+2]) begin
          rem_r[gs] <= rem_nxt[gs];
        end
      end
    end
  endgenerate

  // Stage 7: combine, saturate and hold for the receiver.
  dgfe_post u_post (
    .st   (rem_r[REM_STAGES-1]),
    .gene (gene),
    .y    (y_nxt),
    .err  (err_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES-1]) begin
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_ch.valid      = v_r[NUM_STAGES-1];
  assign out_ch.y_value    = y_r;
  assign out_ch.gene_error = err_r;

  // Checks on the pipeline control and the error path.
  `DGFE_ASSERT_IMP(a_err_zero, out_ch.valid && out_ch.gene_error,
                   out_ch.y_value == '0, "error result must carry zero")
  `DGFE_ASSERT_IMP(a_full_stall, !in_ch.ready, &v_r, "input stalled while a stage is empty")
  `DGFE_ASSERT_NXT(a_accept_load, in_ch.valid && in_ch.ready, v_r[0],
                   "accepted item not held in first stage")

endmodule

`default_nettype wire

FILE: src/dgfe_cfg.sv
`default_nettype none

module dgfe_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dgfe_cfg_if.sink         cfg_ch,
  output dgfe_pkg::gene_t  gene
);
  import dgfe_pkg::*;

  logic [GENE_W-1:0] gene_digits_r, gene_digits_nxt;
  logic [LEN_W-1:0]  gene_length_r, gene_length_nxt;
  logic [MAG_W-1:0]  aux_mag;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Register write decode.
  always_comb begin
    gene_digits_nxt = gene_digits_r;
    gene_length_nxt = gene_length_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_GENE_DIGITS: gene_digits_nxt = cfg_ch.wdata;
        REG_GENE_LENGTH: gene_length_nxt = cfg_ch.wdata[LEN_W-1:0];
        default:         gene_digits_nxt = gene_digits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gene_digits_r <= '0;
      gene_length_r <= LEN_W'(MAX_GENE_DIGITS);
    end else begin
      gene_digits_r <= gene_digits_nxt;
      gene_length_r <= gene_length_nxt;
    end
  end

  // Split the digits into operation and the three signed terms.
  // Odd sign digits are negative; a length above the maximum is still valid.
  assign aux_mag = term_mag(gene_digits_r[32 +: DIGIT_W], gene_digits_r[36 +: DIGIT_W]);

  always_comb begin
    gene.op         = op_t'(gene_digits_r[1:0]);
    gene.k_neg      = gene_digits_r[4];
    gene.k_mag      = term_mag(gene_digits_r[8 +: DIGIT_W], gene_digits_r[12 +: DIGIT_W]);
    gene.b_neg      = gene_digits_r[16];
    gene.b_mag      = term_mag(gene_digits_r[20 +: DIGIT_W], gene_digits_r[24 +: DIGIT_W]);
    gene.divisor    = (aux_mag == '0) ? MAG_W'(1) : aux_mag;
    gene.short_gene = (gene_length_r < LEN_W'(REQUIRED_DIGITS));
  end

endmodule

`default_nettype wire

FILE: src/dgfe_rem8.sv
`default_nettype none

// Eight restoring remainder steps: shifts in eight dividend bits, MSB first.
module dgfe_rem8 (
  input  wire logic [dgfe_pkg::MAG_W-1:0]    rem_in,
  input  wire logic [dgfe_pkg::REM_BITS-1:0] bits,
  input  wire logic [dgfe_pkg::MAG_W-1:0]    divisor,
  output logic      [dgfe_pkg::MAG_W-1:0]    rem_out
);
  import dgfe_pkg::*;

  logic [MAG_W:0]      acc;
  logic [MAG_W-1:0]    r;
  logic [REM_BITS-1:0] sh;

  always_comb begin
    r  = rem_in;
    sh = bits;
    acc = '0;
    for (int i = 0; i < REM_BITS; i++) begin
      acc = {r, sh[REM_BITS-1]};
      if (acc >= {1'b0, divisor}) begin
        acc = acc - {1'b0, divisor};
      end
      r  = acc[MAG_W-1:0];
      sh = sh << 1;
    end
    rem_out = r;
  end

endmodule

`default_nettype wire

FILE: src/dgfe_post.sv
`default_nettype none

// Final combine: apply signs, add b, select by operation and saturate.
module dgfe_post (
  input  wire dgfe_pkg::rem_t              st,
  input  wire dgfe_pkg::gene_t             gene,
  output logic signed [dgfe_pkg::X_W-1:0]  y,
  output logic                             err
);
  import dgfe_pkg::*;

  logic signed [RES_W-1:0] pk_s;
  logic signed [RES_W-1:0] q_s;
  logic signed [RES_W-1:0] rem_s;
  logic signed [RES_W-1:0] b_s;
  logic signed [RES_W-1:0] res;
  logic                    force_hi;
  logic                    force_lo;

  // Signed operands at the width of the sum.
  always_comb begin
    pk_s  = st.pneg   ? -$signed(RES_W'(st.pk))  : $signed(RES_W'(st.pk));
    q_s   = gene.k_neg ? -$signed(RES_W'(st.q))  : $signed(RES_W'(st.q));
    rem_s = st.pneg   ? -$signed(RES_W'(st.rem)) : $signed(RES_W'(st.rem));
    b_s   = gene.b_neg ? -$signed(RES_W'(gene.b_mag)) : $signed(RES_W'(gene.b_mag));
  end

  // Operation select. A large square with nonzero k saturates toward the sign of k.
  always_comb begin
    force_hi = 1'b0;
    force_lo = 1'b0;
    unique case (gene.op)
      OP_LINEAR:    res = pk_s + b_s;
      OP_INVERSE:   res = pk_s - b_s;
      OP_REMAINDER: res = rem_s + b_s;
      OP_QUADRATIC: begin
        res = q_s + b_s;
        if (st.big && (gene.k_mag != '0)) begin
          force_hi = !gene.k_neg;
          force_lo = gene.k_neg;
        end
      end
      default:      res = pk_s + b_s;
    endcase
  end

  // Saturate, or report a short gene.
  always_comb begin
    err = gene.short_gene;
    if (gene.short_gene) begin
      y = '0;
    end else if (force_hi || (res > SAT_HI)) begin
      y = SAT_HI[X_W-1:0];
    end else if (force_lo || (res < SAT_LO)) begin
      y = SAT_LO[X_W-1:0];
    end else begin
      y = res[X_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: tb/dgfe_result_check.sv
`timescale 1ns / 100ps

module dgfe_result_check (
  input  logic clk,
  input  logic rst_n,
  dgfe_in_if   in_mon,
  dgfe_out_if  out_mon,
  dgfe_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);
  import dgfe_pkg::*;

  localparam longint Y_HI = 64'sd2147483647;
  localparam longint Y_LO = -64'sd2147483648;

  typedef struct {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic                  err;
  } y_item_t;

  // Local copy of the gene registers, tracked from the configuration channel.
  logic [GENE_W-1:0] gene_digits;
  logic [LEN_W-1:0]  gene_length;
  y_item_t           expected_y_q[$];
  int                mismatches = 0;

  // A signed term is a sign digit (odd means negative), a tens digit and a units digit.
  function automatic longint gene_term(input logic [GENE_W-1:0] digits, input int pos);
    longint mag;
    mag = longint'(digits[4*(pos+1) +: 4]) * 10 + longint'(digits[4*(pos+2) +: 4]);
    return digits[4*pos] ? -mag : mag;
  endfunction

  // Computes the saturated formula result for one x item under the given gene.
  function automatic y_item_t predict_y(input logic signed [X_W-1:0] x,
                                        input logic [GENE_W-1:0]     digits,
                                        input logic [LEN_W-1:0]      len);
    y_item_t         res;
    op_t             op;
    longint          xl;
    longint          k;
    longint          b;
    longint          aux;
    longint          r;
    longint unsigned ax;
    longint unsigned sq;
    res.x   = x;
    res.y   = '0;
    res.err = 1'b0;
    // A gene longer than the maximum is still valid, so only short ones fail.
    if (len < REQUIRED_DIGITS) begin
      res.err = 1'b1;
    end else begin
      op  = op_t'(digits[1:0]);
      xl  = longint'(x);
      k   = gene_term(digits, 1);
      b   = gene_term(digits, 4);
      aux = gene_term(digits, 7);
      case (op)
        OP_LINEAR: begin
          r = k * xl + b;
        end
        OP_INVERSE: begin
          r = k * xl - b;
        end
        OP_REMAINDER: begin
          // Truncating remainder; a zero divisor is treated as one.
          r = (k * xl) % ((aux == 0) ? 64'sd1 : aux) + b;
        end
        default: begin
          // The square is exact in 64 bits; beyond 2^32 the offset cannot pull it back.
          ax = (xl < 0) ? -xl : xl;
          sq = ax * ax;
          if (k == 0) begin
            r = b;
          end else if (sq > 64'h1_0000_0000) begin
            r = (k > 0) ? Y_HI : Y_LO;
          end else begin
            r = k * longint'(sq) + b;
          end
        end
      endcase
      if (r > Y_HI) begin
        res.y = 32'sh7FFF_FFFF;
      end else if (r < Y_LO) begin
        res.y = 32'sh8000_0000;
      end else begin
        res.y = r[X_W-1:0];
      end
    end
    return res;
  endfunction

  // Track register writes, predict each accepted x item and compare each result item.
  always @(posedge clk) begin
    y_item_t want;
    if (!rst_n) begin
      gene_digits = '0;
      gene_length = LEN_W'(MAX_GENE_DIGITS);
      expected_y_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_GENE_DIGITS) begin
          gene_digits = cfg_mon.wdata;
        end else begin
          gene_length = cfg_mon.wdata[LEN_W-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_y_q.push_back(predict_y(in_mon.x_value, gene_digits, gene_length));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_y_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result item y=%0d err=%0b", $realtime,
                     out_mon.y_value, out_mon.gene_error);
          end
        end else begin
          want = expected_y_q.pop_front();
          if (out_mon.y_value !== want.y || out_mon.gene_error !== want.err) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch for x=%0d: expected y=%0d err=%0b, got y=%0d err=%0b",
                       $realtime, want.x, want.y, want.err, out_mon.y_value,
                       out_mon.gene_error);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_y_q.size();
  end

endmodule

FILE: tb/digit_gene_formula_evaluator_tb.sv
`timescale 1ns / 100ps

module digit_gene_formula_evaluator_tb;
  import dgfe_pkg::*;

  localparam int ITEMS_PER_PHASE = 310;

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  int   src_idle_pct  = 11;
  int   sink_idle_pct = 82;
  int   fail_count;
  int   pending_count;

  dgfe_in_if  in_ch ();
  dgfe_out_if out_ch ();
  dgfe_cfg_if cfg_ch ();

  always #1 clk = ~clk;

  digit_gene_formula_evaluator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dgfe_result_check result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Swap the term from sign-tens-units reading order into gene nibble order.
  function automatic logic [11:0] term_nibbles(input logic [11:0] term);
    return {term[3:0], term[7:4], term[11:8]};
  endfunction

  // Terms are written as 12'hSTU: sign digit, tens digit, units digit.
  function automatic logic [GENE_W-1:0] pack_gene(input logic [3:0]  op_digit,
                                                  input logic [11:0] k_term,
                                                  input logic [11:0] b_term,
                                                  input logic [11:0] aux_term);
    return {4'h0, term_nibbles(aux_term), term_nibbles(b_term), term_nibbles(k_term),
            op_digit};
  endfunction

  // Half the genes use decimal digits only; the rest allow raw nibbles above nine.
  function automatic logic [GENE_W-1:0] random_gene();
    logic [GENE_W-1:0] g;
    g[31:0]        = $urandom;
    g[GENE_W-1:32] = 12'($urandom);
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < 11; i++) g[4*i +: 4] = 4'($urandom_range(9));
    end
    return g;
  endfunction

  // Mostly valid lengths, with some short and some overlong genes.
  function automatic logic [LEN_W-1:0] random_length();
    int pick;
    pick = int'($urandom_range(9));
    if (pick < 6) begin
      return LEN_W'(REQUIRED_DIGITS + int'($urandom_range(5)));
    end else if (pick < 8) begin
      return LEN_W'($urandom_range(10));
    end else begin
      return LEN_W'(17 + int'($urandom_range(14)));
    end
  endfunction

  // Spread x over full range, small values, the square-overflow edge and the extremes.
  function automatic logic signed [X_W-1:0] random_x();
    logic signed [X_W-1:0] v;
    case ($urandom_range(5))
      0, 1: begin
        v = $urandom;
      end
      2: begin
        v = int'($urandom_range(600)) - 300;
      end
      3: begin
        v = 65536 + int'($urandom_range(4)) - 2;
        if ($urandom_range(1) == 1) v = -v;
      end
      4: begin
        v = ($urandom_range(1) == 1) ? 32'sh7FFF_FFFF - int'($urandom_range(1))
                                     : 32'sh8000_0000 + int'($urandom_range(1));
      end
      default: begin
        v = int'($urandom) >>> $urandom_range(31);
      end
    endcase
    return v;
  endfunction

  // Offer one x item after a random gap and hold it until accepted.
  task automatic send_x(input logic signed [X_W-1:0] x);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_value <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait until every expected result has arrived and let the pipeline drain.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  // Write both gene registers back to back while the block is idle.
  task automatic program_gene(input logic [GENE_W-1:0] digits, input logic [LEN_W-1:0] len);
    wait_quiet();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_GENE_DIGITS;
    cfg_ch.wdata     <= digits;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.reg_index <= REG_GENE_LENGTH;
    cfg_ch.wdata     <= {{(GENE_W-LEN_W){1'b0}}, len};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: ready is redrawn every cycle according to the current idle rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("digit_gene_formula_evaluator regression: fail");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int sent;
    int burst;
    in_ch.valid      <= 1'b0;
    in_ch.x_value    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_GENE_DIGITS;
    cfg_ch.wdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gene after reset: all digits zero, full length.
    send_x(32'sh7FFF_FFFF);
    send_x(32'sh8000_0000);

    // Linear with the largest decimal terms, at the minimum valid length.
    program_gene(pack_gene(4'd0, 12'h099, 12'h199, 12'h000), 5'd11);
    send_x(32'sh7FFF_FFFF);
    send_x(32'sh8000_0000);
    send_x(32'sd0);

    // Inverse with a negative slope.
    program_gene(pack_gene(4'd1, 12'h199, 12'h099, 12'h000), 5'd12);
    send_x(32'sh7FFF_FFFF);
    send_x(32'sh8000_0000);

    // Remainder by a negative divisor.
    program_gene(pack_gene(4'd2, 12'h099, 12'h005, 12'h107), 5'd13);
    send_x(-32'sd12345);
    send_x(32'sh7FFF_FFFF);

    // Remainder with a negative zero divisor, selected by an op digit of six.
    program_gene(pack_gene(4'd6, 12'h237, 12'h310, 12'h100), 5'd14);
    send_x(32'sh8000_0000);
    send_x(32'sd77);

    // Quadratic right at and just past a square of 2^32.
    program_gene(pack_gene(4'd3, 12'h001, 12'h101, 12'h000), 5'd15);
    send_x(32'sd65536);
    send_x(32'sd65537);
    send_x(32'sh8000_0000);

    // Every nibble fifteen: quadratic with raw digits in all terms.
    program_gene({GENE_W{1'b1}}, 5'd16);
    send_x(-32'sd2);
    send_x(32'sd46341);

    // Short genes give the error flag; an overlong one is still valid.
    program_gene(pack_gene(4'd0, 12'h012, 12'h034, 12'h000), 5'd10);
    send_x(32'sd5);
    program_gene(pack_gene(4'd0, 12'h012, 12'h034, 12'h000), 5'd0);
    send_x(-32'sd5);
    program_gene(pack_gene(4'd0, 12'h012, 12'h034, 12'h000), 5'd31);
    send_x(32'sd3);

    // Random genes with bursts of random x items, under three idling patterns.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 82 : 0;
      sink_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 11 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        program_gene(random_gene(), random_length());
        burst = int'($urandom_range(60, 20));
        repeat (burst) send_x(random_x());
        sent += burst;
      end
    end

    wait_quiet();
    if (fail_count == 0 && pending_count == 0) begin
      $display("digit_gene_formula_evaluator regression: pass");
    end else begin
      $display("digit_gene_formula_evaluator regression: fail");
    end
    $finish;
  end

endmodule
